>>> src/axis_homing_soft_limit_supervisor_top_defines.svh
// Assertion macros for the axis homing supervisor.
// Used by the top level; expects clk and rst in scope.
`ifndef AXIS_HOMING_SOFT_LIMIT_SUPERVISOR_TOP_DEFINES_SVH
`define AXIS_HOMING_SOFT_LIMIT_SUPERVISOR_TOP_DEFINES_SVH

// same-cycle implication
`define AHSS_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define AHSS_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> src/ahss_pkg.sv
// Shared types, codes and constants of the axis homing supervisor.
// No dependencies.
package ahss_pkg;

  localparam int unsigned ReqTypeW  = 3;
  localparam int unsigned CmdW      = 32;
  localparam int unsigned PosW      = 16;
  localparam int unsigned MsW       = 16;
  localparam int unsigned TorqueW   = 15;
  localparam int unsigned OpW       = 8;
  localparam int unsigned ValW      = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned MaxFrames = 3;
  localparam int unsigned FrameCntW = 2;

  localparam logic [ReqTypeW-1:0] REQ_TICK   = 3'd0;
  localparam logic [ReqTypeW-1:0] REQ_EDGE   = 3'd1;
  localparam logic [ReqTypeW-1:0] REQ_BUTTON = 3'd2;
  localparam logic [ReqTypeW-1:0] REQ_HOST   = 3'd3;
  localparam logic [ReqTypeW-1:0] REQ_HOME   = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_HOME_TORQUE    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOME_TARGET    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT_LOW      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT_HIGH     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SEEK_TIMEOUT   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TRAVEL_TIMEOUT = 3'd5;

  localparam logic [OpW-1:0] OP_STOP1  = 8'h81;
  localparam logic [OpW-1:0] OP_STOP2  = 8'h80;
  localparam logic [OpW-1:0] OP_TORQUE = 8'hA1;
  localparam logic [OpW-1:0] OP_INFO   = 8'h9A;

  localparam logic signed [CmdW-1:0] CODE_STOP  = 32'sd1000000;
  localparam logic signed [CmdW-1:0] CODE_READY = 32'sd1000001;
  localparam logic signed [CmdW-1:0] CODE_INFO  = 32'sd1000002;
  localparam logic signed [CmdW-1:0] CODE_RESET = 32'sd1000003;

  localparam logic [TorqueW-1:0]     HOME_TORQUE_RST    = 15'd75;
  localparam logic [TorqueW-1:0]     HOME_TARGET_RST    = 15'd6106;
  localparam logic signed [PosW-1:0] LIMIT_LOW_RST      = 16'sd1000;
  localparam logic signed [PosW-1:0] LIMIT_HIGH_RST     = 16'sd11213;
  localparam logic [MsW-1:0]         SEEK_TIMEOUT_RST   = 16'd5000;
  localparam logic [MsW-1:0]         TRAVEL_TIMEOUT_RST = 16'd3000;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_SEEK   = 3'b010,
    PH_TRAVEL = 3'b100
  } phase_t;

  typedef struct packed {
    logic [ReqTypeW-1:0]     req_type;
    logic                    chan_a;
    logic                    chan_b;
    logic signed [CmdW-1:0]  command_value;
  } req_t;

  typedef struct packed {
    logic [OpW-1:0]          opcode;
    logic signed [ValW-1:0]  value;
    logic                    failed;
  } frame_t;

  typedef struct packed {
    logic [FrameCntW-1:0]        count;
    frame_t [MaxFrames-1:0]      frames;
  } burst_t;

  typedef struct packed {
    logic [TorqueW-1:0]      home_torque;
    logic [TorqueW-1:0]      home_target;
    logic signed [PosW-1:0]  limit_low;
    logic signed [PosW-1:0]  limit_high;
    logic [MsW-1:0]          seek_timeout_ms;
    logic [MsW-1:0]          travel_timeout_ms;
  } cfg_t;

  typedef struct packed {
    phase_t phase;
    logic   safety_rehoming;
  } status_t;

  function automatic frame_t make_frame(logic [OpW-1:0] op, logic [ValW-1:0] val,
                                        logic failed);
    frame_t f;
    f.opcode = op;
    f.value  = signed'(val);
    f.failed = failed;
    return f;
  endfunction

endpackage

>>> src/ahss_if.sv
// Handshake channels of the axis homing supervisor: request, frame, config.
// Depends on ahss_pkg.
interface ahss_req_if import ahss_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ReqTypeW-1:0]    req_type;
  logic                   chan_a;
  logic                   chan_b;
  logic signed [CmdW-1:0] command_value;
  modport source (output valid, req_type, chan_a, chan_b, command_value, input ready);
  modport sink   (input valid, req_type, chan_a, chan_b, command_value, output ready);
endinterface

interface ahss_frame_if import ahss_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OpW-1:0]         frame_opcode;
  logic signed [ValW-1:0] frame_value;
  logic                   homing_failed;
  logic                   last;
  modport source (output valid, frame_opcode, frame_value, homing_failed, last,
                  input ready);
  modport sink   (input valid, frame_opcode, frame_value, homing_failed, last,
                  output ready);
endinterface

interface ahss_cfg_if import ahss_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/ahss_cfg_regs.sv
// Configuration register file of the axis homing supervisor.
// Depends on ahss_pkg and ahss_cfg_if.
module ahss_cfg_regs import ahss_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  ahss_cfg_if.sink        cfg,
  output cfg_t            regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.home_torque       <= HOME_TORQUE_RST;
      regs.home_target       <= HOME_TARGET_RST;
      regs.limit_low         <= LIMIT_LOW_RST;
      regs.limit_high        <= LIMIT_HIGH_RST;
      regs.seek_timeout_ms   <= SEEK_TIMEOUT_RST;
      regs.travel_timeout_ms <= TRAVEL_TIMEOUT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_HOME_TORQUE:    regs.home_torque       <= cfg.data[TorqueW-1:0];
        CFG_HOME_TARGET:    regs.home_target       <= cfg.data[TorqueW-1:0];
        CFG_LIMIT_LOW:      regs.limit_low         <= signed'(cfg.data[PosW-1:0]);
        CFG_LIMIT_HIGH:     regs.limit_high        <= signed'(cfg.data[PosW-1:0]);
        CFG_SEEK_TIMEOUT:   regs.seek_timeout_ms   <= cfg.data[MsW-1:0];
        CFG_TRAVEL_TIMEOUT: regs.travel_timeout_ms <= cfg.data[MsW-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> src/ahss_step.sv
// Supervisor state and the single-pass step logic: next state and frame burst.
// Depends on ahss_pkg.
module ahss_step import ahss_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  req_t    req,
  input  logic    advance,
  output burst_t  burst,
  output status_t status
);

  logic [PosW-1:0] position, position_next;
  phase_t          phase, phase_next;
  logic [MsW-1:0]  elapsed, elapsed_next;
  logic            limits_armed, limits_armed_next;
  logic            safety_rehoming, safety_rehoming_next;

  logic [MsW-1:0]         elapsed_inc;
  logic [PosW-1:0]        pos_step;
  logic signed [PosW-1:0] target_s;
  logic                   host_in_range;
  logic [ValW-1:0]        ht_pos, ht_neg, host_neg;

  assign elapsed_inc   = (phase != PH_IDLE && elapsed != '1) ? elapsed + MsW'(1) : elapsed;
  assign pos_step      = (req.chan_a != req.chan_b) ? position + PosW'(1)
                                                    : position - PosW'(1);
  assign target_s      = signed'({1'b0, cfg.home_target});
  assign host_in_range = (&req.command_value[CmdW-1:ValW-1]) |
                         ~(|req.command_value[CmdW-1:ValW-1]);
  assign ht_pos        = {1'b0, cfg.home_torque};
  assign ht_neg        = ValW'(0) - ht_pos;
  assign host_neg      = ValW'(0) - req.command_value[ValW-1:0];

  always_comb begin
    position_next        = position;
    phase_next           = phase;
    elapsed_next         = elapsed;
    limits_armed_next    = limits_armed;
    safety_rehoming_next = safety_rehoming;
    burst                = '0;
    unique case (req.req_type)
      REQ_TICK: begin
        elapsed_next = elapsed_inc;
        if (phase == PH_SEEK) begin
          if (elapsed_inc >= cfg.seek_timeout_ms) begin
            burst.count     = 2'd3;
            burst.frames[0] = make_frame(OP_STOP1, '0, 1'b0);
            burst.frames[1] = make_frame(OP_STOP2, '0, 1'b0);
            burst.frames[2] = make_frame(OP_TORQUE, ht_neg, 1'b0);
            position_next   = '0;
            phase_next      = PH_TRAVEL;
            elapsed_next    = '0;
          end
        end else if (phase == PH_TRAVEL) begin
          if (signed'(position) >= target_s) begin
            burst.count          = 2'd2;
            burst.frames[0]      = make_frame(OP_STOP1, '0, 1'b0);
            burst.frames[1]      = make_frame(OP_STOP2, '0, 1'b0);
            phase_next           = PH_IDLE;
            limits_armed_next    = 1'b1;
            safety_rehoming_next = 1'b0;
          end else if (elapsed_inc > cfg.travel_timeout_ms) begin
            burst.count          = 2'd2;
            burst.frames[0]      = make_frame(OP_STOP1, '0, 1'b1);
            burst.frames[1]      = make_frame(OP_STOP2, '0, 1'b1);
            phase_next           = PH_IDLE;
            safety_rehoming_next = 1'b0;
          end
        end else if (limits_armed && (signed'(position) < cfg.limit_low ||
                                      signed'(position) > cfg.limit_high)) begin
          burst.count          = 2'd3;
          burst.frames[0]      = make_frame(OP_STOP1, '0, 1'b0);
          burst.frames[1]      = make_frame(OP_STOP2, '0, 1'b0);
          burst.frames[2]      = make_frame(OP_TORQUE, ht_pos, 1'b0);
          safety_rehoming_next = 1'b1;
          phase_next           = PH_SEEK;
          elapsed_next         = '0;
        end
      end
      REQ_EDGE: begin
        position_next = pos_step;
        if (phase == PH_TRAVEL && signed'(pos_step) >= target_s) begin
          burst.count          = 2'd2;
          burst.frames[0]      = make_frame(OP_STOP1, '0, 1'b0);
          burst.frames[1]      = make_frame(OP_STOP2, '0, 1'b0);
          phase_next           = PH_IDLE;
          limits_armed_next    = 1'b1;
          safety_rehoming_next = 1'b0;
        end
      end
      REQ_BUTTON: begin
        if (phase == PH_SEEK) begin
          burst.count     = 2'd3;
          burst.frames[0] = make_frame(OP_STOP1, '0, 1'b0);
          burst.frames[1] = make_frame(OP_STOP2, '0, 1'b0);
          burst.frames[2] = make_frame(OP_TORQUE, ht_neg, 1'b0);
          position_next   = '0;
          phase_next      = PH_TRAVEL;
          elapsed_next    = '0;
        end
      end
      REQ_HOST: begin
        if (!safety_rehoming) begin
          if (host_in_range) begin
            burst.count     = 2'd1;
            burst.frames[0] = make_frame(OP_TORQUE, host_neg, 1'b0);
          end else if (req.command_value == CODE_STOP ||
                       req.command_value == CODE_READY) begin
            burst.count     = 2'd2;
            burst.frames[0] = make_frame(OP_STOP1, '0, 1'b0);
            burst.frames[1] = make_frame(OP_STOP2, '0, 1'b0);
          end else if (req.command_value == CODE_INFO) begin
            burst.count     = 2'd1;
            burst.frames[0] = make_frame(OP_INFO, '0, 1'b0);
          end else if (req.command_value == CODE_RESET) begin
            position_next        = '0;
            phase_next           = PH_IDLE;
            elapsed_next         = '0;
            limits_armed_next    = 1'b0;
            safety_rehoming_next = 1'b0;
          end else begin
            burst.count     = 2'd1;
            burst.frames[0] = make_frame(OP_TORQUE, '0, 1'b0);
          end
        end
      end
      REQ_HOME: begin
        if (phase == PH_IDLE) begin
          burst.count     = 2'd3;
          burst.frames[0] = make_frame(OP_STOP1, '0, 1'b0);
          burst.frames[1] = make_frame(OP_STOP2, '0, 1'b0);
          burst.frames[2] = make_frame(OP_TORQUE, ht_pos, 1'b0);
          phase_next      = PH_SEEK;
          elapsed_next    = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position        <= '0;
      phase           <= PH_IDLE;
      elapsed         <= '0;
      limits_armed    <= 1'b0;
      safety_rehoming <= 1'b0;
    end else if (advance) begin
      position        <= position_next;
      phase           <= phase_next;
      elapsed         <= elapsed_next;
      limits_armed    <= limits_armed_next;
      safety_rehoming <= safety_rehoming_next;
    end
  end

  assign status.phase           = phase;
  assign status.safety_rehoming = safety_rehoming;

endmodule

>>> src/ahss_frame_queue.sv
// Result register: holds the frame burst of one item and sends it word by word.
// Depends on ahss_pkg and ahss_frame_if.
module ahss_frame_queue import ahss_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  burst_t        burst,
  output logic          free,
  ahss_frame_if.source  frame
);

  frame_t [MaxFrames-1:0] frames;
  logic [FrameCntW-1:0]   count;
  logic [FrameCntW-1:0]   idx;
  logic                   at_last;
  logic                   take;
  frame_t                 head;

  assign at_last = (idx == count - FrameCntW'(1));
  assign take    = frame.valid && frame.ready;
  assign free    = (count == '0) || (frame.ready && at_last);
  assign head    = frames[idx];

  assign frame.valid         = (count != '0);
  assign frame.frame_opcode  = head.opcode;
  assign frame.frame_value   = head.value;
  assign frame.homing_failed = head.failed;
  assign frame.last          = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else if (load) begin
      count <= burst.count;
      idx   <= '0;
    end else if (take) begin
      if (at_last) begin
        count <= '0;
        idx   <= '0;
      end else begin
        idx <= idx + FrameCntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frames <= burst.frames;
    end
  end

endmodule

>>> src/axis_homing_soft_limit_supervisor_top.sv
// Axis homing supervisor top: input register, step logic, frame result register.
// An accepted item waits in the input register; its frames are loaded into the result
// register once that is free. One item per cycle when an item makes no frame and the
// register is free; the frames of an item, at most three, go one per cycle while ready.
// Reset (rst, synchronous) clears position, phase, timers, arming and rehoming
// and returns every configuration register to its default.
`include "axis_homing_soft_limit_supervisor_top_defines.svh"

module axis_homing_soft_limit_supervisor_top import ahss_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ahss_req_if.sink     req,
  ahss_frame_if.source frame,
  ahss_cfg_if.sink     cfg
);

  cfg_t    regs;
  req_t    req_q;
  logic    in_valid;
  logic    q_free;
  logic    advance;
  logic    load;
  burst_t  burst;
  status_t status;

  assign advance   = in_valid && q_free;
  assign load      = advance && (burst.count != '0);
  assign req.ready = !in_valid || q_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_q.req_type      <= req.req_type;
      req_q.chan_a        <= req.chan_a;
      req_q.chan_b        <= req.chan_b;
      req_q.command_value <= req.command_value;
    end
  end

  ahss_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ahss_step u_step (
    .clk     (clk),
    .rst     (rst),
    .cfg     (regs),
    .req     (req_q),
    .advance (advance),
    .burst   (burst),
    .status  (status)
  );

  ahss_frame_queue u_frame_queue (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .burst (burst),
    .free  (q_free),
    .frame (frame)
  );

  `AHSS_ASSERT_NEXT(a_burst_continues, frame.valid && !frame.last, frame.valid, "frame burst dropped before its last word")
  `AHSS_ASSERT_NEXT(a_load_shows_frame, load, frame.valid, "loaded burst not presented")
  `AHSS_ASSERT_NOW(a_rehome_not_idle, status.safety_rehoming, status.phase != PH_IDLE, "safety rehoming flagged while idle")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the axis homing and soft-limit supervisor.
// Predicts every motor frame from its own model of position, homing phase and limits.
// Depends on ahss_pkg, the handshake interfaces and the supervisor top level.
module testbench import ahss_pkg::*; ();

  localparam int SETTLE_CYCLES = 10;
  localparam int QUIET_LIMIT   = 500;
  localparam int MAX_REPORTS   = 60;
  localparam int PHASE_ITEMS   = 24;
  localparam logic [ReqTypeW-1:0] REQ_SPARE_FIRST = REQ_HOME + 3'd1;
  localparam logic [ReqTypeW-1:0] REQ_SPARE_LAST  = '1;

  typedef struct packed {
    frame_t frm;
    logic   last;
  } frame_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ahss_req_if   req_ch ();
  ahss_frame_if frame_ch ();
  ahss_cfg_if   cfg_ch ();

  axis_homing_soft_limit_supervisor_top dut (
    .clk  (clk),
    .rst  (rst),
    .req  (req_ch),
    .frame(frame_ch),
    .cfg  (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cfg_t        regs;
  logic [15:0] pos_cnt;
  phase_t      phase_q;
  logic [15:0] elapsed_ms;
  logic        armed;
  logic        rehoming;

  frame_word_t burst_q[$];
  frame_word_t frames_due[$];

  int fails = 0;
  int effective_items = 0;
  int quiet_cycles = 0;
  bit src_gaps = 1'b1;
  bit sink_stalls = 1'b1;

  function automatic void clear_state();
    pos_cnt    = '0;
    phase_q    = PH_IDLE;
    elapsed_ms = '0;
    armed      = 1'b0;
    rehoming   = 1'b0;
  endfunction

  function automatic void add_frame(logic [OpW-1:0] op, logic [ValW-1:0] val, logic failed);
    frame_word_t f;
    f.frm.opcode = op;
    f.frm.value  = val;
    f.frm.failed = failed;
    f.last       = 1'b0;
    burst_q.push_back(f);
  endfunction

  function automatic void add_stop(logic failed);
    add_frame(OP_STOP1, '0, failed);
    add_frame(OP_STOP2, '0, failed);
  endfunction

  // start a seek run: the frame carries the homing torque, not negated
  function automatic void begin_run();
    add_stop(1'b0);
    add_frame(OP_TORQUE, {1'b0, regs.home_torque}, 1'b0);
    phase_q    = PH_SEEK;
    elapsed_ms = '0;
  endfunction

  function automatic void end_seek();
    add_stop(1'b0);
    pos_cnt = '0;
    add_frame(OP_TORQUE, 16'h0 - {1'b0, regs.home_torque}, 1'b0);
    phase_q    = PH_TRAVEL;
    elapsed_ms = '0;
  endfunction

  function automatic bit target_reached();
    if (phase_q == PH_TRAVEL && $signed(pos_cnt) >= $signed({1'b0, regs.home_target})) begin
      add_stop(1'b0);
      phase_q  = PH_IDLE;
      armed    = 1'b1;
      rehoming = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit predict_frames(req_t r);
    int cv;
    bit acted;
    cv    = r.command_value;
    acted = (r.req_type == REQ_TICK) || (r.req_type == REQ_EDGE);
    burst_q.delete();
    case (r.req_type)
      REQ_TICK: begin
        if (phase_q != PH_IDLE && elapsed_ms != 16'hFFFF) elapsed_ms = elapsed_ms + 16'd1;
        if (phase_q == PH_SEEK) begin
          if (elapsed_ms >= regs.seek_timeout_ms) end_seek();
        end else if (phase_q == PH_TRAVEL) begin
          if (!target_reached() && elapsed_ms > regs.travel_timeout_ms) begin
            add_stop(1'b1);
            phase_q  = PH_IDLE;
            rehoming = 1'b0;
          end
        end else if (armed && ($signed(pos_cnt) < $signed(regs.limit_low) ||
                               $signed(pos_cnt) > $signed(regs.limit_high))) begin
          rehoming = 1'b1;
          begin_run();
        end
      end
      REQ_EDGE: begin
        if (r.chan_a != r.chan_b) pos_cnt = pos_cnt + 16'd1;
        else pos_cnt = pos_cnt - 16'd1;
        void'(target_reached());
      end
      REQ_BUTTON: begin
        if (phase_q == PH_SEEK) end_seek();
      end
      REQ_HOST: begin
        if (!rehoming) begin
          if (cv >= -32768 && cv <= 32767) add_frame(OP_TORQUE, 16'h0 - cv[15:0], 1'b0);
          else if (cv == CODE_STOP || cv == CODE_READY) add_stop(1'b0);
          else if (cv == CODE_INFO) add_frame(OP_INFO, '0, 1'b0);
          else if (cv == CODE_RESET) begin
            clear_state();
            acted = 1'b1;
          end else add_frame(OP_TORQUE, '0, 1'b0);
        end
      end
      REQ_HOME: begin
        if (phase_q == PH_IDLE) begin_run();
      end
      default: ;
    endcase
    if (burst_q.size() > 0) begin
      burst_q[burst_q.size() - 1].last = 1'b1;
      acted = 1'b1;
    end
    foreach (burst_q[i]) frames_due.push_back(burst_q[i]);
    return acted;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      fails++;
      if (fails <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  function automatic req_t noise_req(logic [ReqTypeW-1:0] kind);
    req_t r;
    r.req_type      = kind;
    r.chan_a        = 1'($urandom);
    r.chan_b        = 1'($urandom);
    r.command_value = $urandom;
    return r;
  endfunction

  function automatic int rand_host_value();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3: return $urandom_range(0, 65535) - 32768;
      4: return CODE_STOP;
      5: return CODE_READY;
      6: return CODE_INFO;
      7: return CODE_RESET;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_req(input req_t r);
    int gap;
    gap = src_gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= r.req_type;
    req_ch.chan_a        <= r.chan_a;
    req_ch.chan_b        <= r.chan_b;
    req_ch.command_value <= r.command_value;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    if (predict_frames(r)) effective_items++;
  endtask

  task automatic send_kind(input logic [ReqTypeW-1:0] kind);
    send_req(noise_req(kind));
  endtask

  task automatic send_enc(input logic fwd);
    req_t r;
    r = noise_req(REQ_EDGE);
    r.chan_b = fwd ? ~r.chan_a : r.chan_a;
    send_req(r);
  endtask

  task automatic send_host(input int cv);
    req_t r;
    r = noise_req(REQ_HOST);
    r.command_value = cv;
    send_req(r);
  endtask

  // hold the sender until every expected word is in, then let the block settle
  task automatic drain_frames();
    req_ch.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_regs(input logic [15:0] ht, tgt, lo, hi, seek, trav);
    logic [CfgDataW-1:0] vals [6];
    logic [CfgIdxW-1:0]  idx;
    vals = '{ht, tgt, lo, hi, seek, trav};
    for (int i = CFG_HOME_TORQUE; i <= CFG_TRAVEL_TIMEOUT; i++) begin
      idx = CfgIdxW'(i);
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= vals[i];
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
      case (idx)
        CFG_HOME_TORQUE:    regs.home_torque       = vals[i][TorqueW-1:0];
        CFG_HOME_TARGET:    regs.home_target       = vals[i][TorqueW-1:0];
        CFG_LIMIT_LOW:      regs.limit_low         = vals[i];
        CFG_LIMIT_HIGH:     regs.limit_high        = vals[i];
        CFG_SEEK_TIMEOUT:   regs.seek_timeout_ms   = vals[i];
        CFG_TRAVEL_TIMEOUT: regs.travel_timeout_ms = vals[i];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_kind(3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST)));
      1: send_host(rand_host_value());
      2: send_kind(REQ_HOME);
      default: send_kind(REQ_BUTTON);
    endcase
  endtask

  // mostly well-formed homing traffic, steered by the predicted phase
  task automatic send_random();
    int roll;
    roll = $urandom_range(0, 99);
    case (phase_q)
      PH_SEEK: begin
        if (roll < 60) send_kind(REQ_TICK);
        else if (roll < 80) send_kind(REQ_BUTTON);
        else if (roll < 90) send_enc(1'($urandom));
        else send_noise();
      end
      PH_TRAVEL: begin
        if (roll < 55) send_enc(1'b1);
        else if (roll < 65) send_enc(1'b0);
        else if (roll < 90) send_kind(REQ_TICK);
        else send_noise();
      end
      default: begin
        if (roll < 20) send_kind(REQ_HOME);
        else if (roll < 45) send_kind(REQ_TICK);
        else if (roll < 70) send_enc(1'($urandom));
        else if (roll < 95) send_host(rand_host_value());
        else send_noise();
      end
    endcase
  endtask

  task automatic test_host_words();
    send_host(32767);
    send_host(-32768);
    send_host(32768);
    send_host(32'sh8000_0000);
    send_host(CODE_STOP);
    send_host(CODE_READY);
    send_host(CODE_INFO);
    send_kind(REQ_BUTTON);
    send_kind(REQ_SPARE_LAST);
    drain_frames();
  endtask

  task automatic test_homing_run();
    load_regs(16'hFFFF, 16'd2, 16'h8000, 16'h7FFF, 16'd0, 16'hFFFF);
    send_kind(REQ_HOME);
    send_kind(REQ_HOME);
    send_kind(REQ_TICK);
    send_enc(1'b0);
    repeat (3) send_enc(1'b1);
    send_kind(REQ_TICK);
    drain_frames();
  endtask

  task automatic test_soft_limit();
    load_regs(16'h0000, 16'd2, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd0);
    send_kind(REQ_TICK);
    send_host(123);
    send_kind(REQ_BUTTON);
    send_kind(REQ_TICK);
    drain_frames();
  endtask

  task automatic test_host_reset();
    send_host(CODE_RESET);
    send_kind(REQ_TICK);
    drain_frames();
  endtask

  task automatic test_random_phases();
    int lo;
    int start;
    bit held;
    for (int p = 0; p < 5; p++) begin
      src_gaps    = (p != 2);
      sink_stalls = (p != 2) && (p != 4);
      lo = $urandom_range(0, 9);
      lo = lo - 6;
      case (p)
        1: load_regs({1'($urandom), 15'h7FFF}, 16'h0, 16'h8000, 16'h7FFF, 16'h0, 16'h0);
        3: load_regs(16'($urandom), 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF,
                     16'($urandom_range(0, 15)));
        default: load_regs(16'($urandom), {1'($urandom), 15'($urandom_range(0, 10))},
                           16'(lo), 16'(lo + $urandom_range(0, 12)),
                           16'($urandom_range(0, 6)), 16'($urandom_range(0, 15)));
      endcase
      start = effective_items;
      held  = 1'b0;
      while (effective_items - start < PHASE_ITEMS) begin
        send_random();
        if (!held && effective_items - start == PHASE_ITEMS / 2) begin
          drain_frames();
          held = 1'b1;
        end
      end
      drain_frames();
    end
  endtask

  initial begin : frame_checker
    int stall;
    frame_word_t got;
    frame_word_t want;
    frame_ch.ready <= 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = sink_stalls ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        frame_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      frame_ch.ready <= 1'b1;
      do @(posedge clk); while (frame_ch.valid !== 1'b1);
      got.frm.opcode = frame_ch.frame_opcode;
      got.frm.value  = frame_ch.frame_value;
      got.frm.failed = frame_ch.homing_failed;
      got.last       = frame_ch.last;
      if (frames_due.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("%0t: unexpected frame word, op %h value %h failed %b last %b", $time,
                   got.frm.opcode, got.frm.value, got.frm.failed, got.last);
      end else begin
        want = frames_due.pop_front();
        check_field("frame_opcode", 16'(want.frm.opcode), 16'(got.frm.opcode));
        check_field("frame_value", want.frm.value, got.frm.value);
        check_field("homing_failed", 16'(want.frm.failed), 16'(got.frm.failed));
        check_field("last", 16'(want.last), 16'(got.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (frame_ch.valid && frame_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("%0t: watchdog, no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin
    req_ch.valid         <= 1'b0;
    req_ch.req_type      <= REQ_TICK;
    req_ch.chan_a        <= 1'b0;
    req_ch.chan_b        <= 1'b0;
    req_ch.command_value <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= CFG_HOME_TORQUE;
    cfg_ch.data          <= '0;
    regs.home_torque       = HOME_TORQUE_RST;
    regs.home_target       = HOME_TARGET_RST;
    regs.limit_low         = LIMIT_LOW_RST;
    regs.limit_high        = LIMIT_HIGH_RST;
    regs.seek_timeout_ms   = SEEK_TIMEOUT_RST;
    regs.travel_timeout_ms = TRAVEL_TIMEOUT_RST;
    clear_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_host_words();
    test_homing_run();
    test_soft_limit();
    test_host_reset();
    test_random_phases();
    if (fails == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
